// ----- rtl/tcpcw_pkg.sv -----
// Shared types, widths, event codes and the control-store program of the
// congestion window sequencer. No dependencies.
package tcpcw_pkg;

  localparam int WIN_W   = 32;
  localparam int SEG_W   = 16;
  localparam int CNT_W   = 8;
  localparam int DUP_W   = 16;
  localparam int FUNC_W  = 2;
  localparam int PC_W    = 4;
  localparam int CADDR_W = 2;
  localparam int IN_W    = 88;   // 81 payload bits padded to bytes
  localparam int OUT_W   = 104;  // 99 payload bits padded to bytes

  localparam logic [WIN_W-1:0] WIN_MAX = '1;
  localparam logic [WIN_W-1:0] SSTH_RESET = WIN_W'(65535);
  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(536);
  localparam logic [CNT_W-1:0] RETX_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] INIT_SEG_RESET = CNT_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START   = 2'd0,
    FUNC_NEW_ACK = 2'd1,
    FUNC_DUP_ACK = 2'd2,
    FUNC_TIMEOUT = 2'd3
  } func_t;

  typedef enum logic [CADDR_W-1:0] {
    REG_SEGMENT_SIZE  = 2'd0,
    REG_RETX_THRESH   = 2'd1,
    REG_INIT_CWND_SEG = 2'd2,
    REG_INIT_SSTHRESH = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TMP_INIT_MUL,   // tmp = initial segments * segment size
    OP_LOAD_START,     // cwnd = tmp, ssthresh = initial register
    OP_EXIT_REC,       // if in recovery, leave it: cwnd = ssthresh
    OP_TMP_SQ,         // tmp = segment size squared
    OP_DIV_START,      // launch tmp / cwnd
    OP_CWND_ADD_Q,     // cwnd += max(quotient, 1)
    OP_CWND_ADD_SEG,   // cwnd += segment size
    OP_FR_SSTH,        // ssthresh = halved flight, floor 2 segments, enter recovery, flag retransmit
    OP_FR_CWND,        // cwnd = ssthresh + 3 segments
    OP_INFLATE,        // cwnd += segment size, flag pending send
    OP_TIMEOUT         // clear recovery, collapse window if active
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_CWND_LT_SSTH,
    C_DIV_BUSY,
    C_FR_HIT,
    C_NOT_REC
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             last;
  } uword_t;

  localparam logic [PC_W-1:0] ENT_START   = 4'd0;
  localparam logic [PC_W-1:0] ENT_NEW_ACK = 4'd2;
  localparam logic [PC_W-1:0] ENT_DUP_ACK = 4'd8;
  localparam logic [PC_W-1:0] ENT_TIMEOUT = 4'd14;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_TMP_INIT_MUL, C_NEXT,         4'd0,  1'b0};
      4'd1:    w = '{OP_LOAD_START,   C_NEXT,         4'd0,  1'b1};
      4'd2:    w = '{OP_EXIT_REC,     C_NEXT,         4'd0,  1'b0};
      4'd3:    w = '{OP_TMP_SQ,       C_CWND_LT_SSTH, 4'd7,  1'b0};
      4'd4:    w = '{OP_DIV_START,    C_NEXT,         4'd0,  1'b0};
      4'd5:    w = '{OP_NOP,          C_DIV_BUSY,     4'd5,  1'b0};
      4'd6:    w = '{OP_CWND_ADD_Q,   C_NEXT,         4'd0,  1'b1};
      4'd7:    w = '{OP_CWND_ADD_SEG, C_NEXT,         4'd0,  1'b1};
      4'd8:    w = '{OP_NOP,          C_FR_HIT,       4'd11, 1'b0};
      4'd9:    w = '{OP_NOP,          C_NOT_REC,      4'd13, 1'b0};
      4'd10:   w = '{OP_INFLATE,      C_NEXT,         4'd0,  1'b1};
      4'd11:   w = '{OP_FR_SSTH,      C_NEXT,         4'd0,  1'b0};
      4'd12:   w = '{OP_FR_CWND,      C_NEXT,         4'd0,  1'b1};
      4'd13:   w = '{OP_NOP,          C_NEXT,         4'd0,  1'b1};
      4'd14:   w = '{OP_TIMEOUT,      C_NEXT,         4'd0,  1'b1};
      default: w = '{OP_NOP,          C_NEXT,         4'd0,  1'b1};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/tcpcw_divider.sv -----
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// Depends on tcpcw_pkg. A zero divisor gives an all-ones quotient.
module tcpcw_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tcpcw_pkg::WIN_W-1:0] dividend,
  input  logic [tcpcw_pkg::WIN_W-1:0] divisor,
  output logic                      busy,
  output logic [tcpcw_pkg::WIN_W-1:0] quotient
);
  import tcpcw_pkg::*;

  localparam int CW = $clog2(WIN_W);

  logic [WIN_W-1:0] rem;
  logic [WIN_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [WIN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[WIN_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(WIN_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
      cnt      <= '0;
    end else if (busy) begin
      rem      <= fits ? WIN_W'(rem_sh - {1'b0, dvs}) : WIN_W'(rem_sh);
      quotient <= {quotient[WIN_W-2:0], fits};
      cnt      <= cnt + CW'(1);
    end
  end

endmodule

// ----- rtl/tcp_reno_congestion_window.sv -----
// Top level of the Reno congestion window engine: config registers, the
// microcoded sequencer with its datapath, and the output register.
// Depends on tcpcw_pkg and tcpcw_divider.
//
//  channel  direction  words                               handshake
//  s_*      in         event + ACK/flight/window word       tvalid/tready
//  m_*      out        window state word, one per event     tvalid/tready
//  cfg_*    in         register write, index 0..3           cfg_we only
//
// A new ACK in congestion avoidance waits for all 32 quotient bits of the
// radix-2 divider; after each event the sequencer returns to idle.
// One event is worked at a time; s_tready is high while the sequencer idles,
// also while a finished word waits in the output register.
// A final step stalls only when the output register is still full.
// Reset is synchronous: window 0, threshold 65535, recovery clear, registers
// at their documented defaults.
module tcp_reno_congestion_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [15:0] dup_count, [47:16] bytes_in_flight, [79:48] receiver_window,
  // [80] timeout_active, zero above
  input  logic [tcpcw_pkg::IN_W-1:0]   s_tdata,
  // [1:0] func
  input  logic [tcpcw_pkg::FUNC_W-1:0] s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [31:0] cwnd, [63:32] ssthresh, [64] in_fast_recovery,
  // [96:65] send_window, [97] retransmit_now, [98] send_pending, zero above
  output logic [tcpcw_pkg::OUT_W-1:0]  m_tdata,
  input  logic                         cfg_we,
  input  logic [tcpcw_pkg::CADDR_W-1:0] cfg_addr,
  input  logic [tcpcw_pkg::WIN_W-1:0]  cfg_wdata
);
  import tcpcw_pkg::*;

  function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                               input logic [WIN_W-1:0] b);
    logic [WIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WIN_W] ? WIN_MAX : s[WIN_W-1:0];
  endfunction

  // Configuration registers
  logic [SEG_W-1:0] seg;
  logic [CNT_W-1:0] retx_thr;
  logic [CNT_W-1:0] init_seg;
  logic [WIN_W-1:0] init_ssth;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg       <= SEG_RESET;
      retx_thr  <= RETX_RESET;
      init_seg  <= INIT_SEG_RESET;
      init_ssth <= SSTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SEGMENT_SIZE:  seg       <= cfg_wdata[SEG_W-1:0];
        REG_RETX_THRESH:   retx_thr  <= cfg_wdata[CNT_W-1:0];
        REG_INIT_CWND_SEG: init_seg  <= cfg_wdata[CNT_W-1:0];
        REG_INIT_SSTHRESH: init_ssth <= cfg_wdata;
      endcase
    end
  end

  // Sequencer
  seq_state_t      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  uword_t          uw;
  logic            cond_true;
  logic            advance;
  logic            accept;

  // Latched event word
  logic [DUP_W-1:0] in_dup;
  logic [WIN_W-1:0] in_flight;
  logic [WIN_W-1:0] in_rwnd;
  logic             in_active;

  // Datapath registers
  logic [WIN_W-1:0] cwnd, cwnd_next;
  logic [WIN_W-1:0] ssth, ssth_next;
  logic             rec, rec_next;
  logic             retx, retx_next;
  logic             pend, pend_next;
  logic [WIN_W-1:0] tmp, tmp_next;

  logic [WIN_W-1:0] quo;
  logic             div_busy;
  logic             div_start;

  logic [SEG_W-1:0] mul_a;
  logic [WIN_W-1:0] product;
  logic [WIN_W-1:0] two_seg;
  logic [WIN_W-1:0] three_seg;
  logic [WIN_W-1:0] half_flight;
  logic [WIN_W-1:0] halved;
  logic [WIN_W-1:0] send_win;
  logic [WIN_W-1:0] quo_step;

  logic             out_valid;
  logic [OUT_W-1:0] out_data;

  assign uw       = ucode_rom(pc);
  assign s_tready = (state == SEQ_IDLE);
  assign accept   = s_tvalid && s_tready;
  // Hold the closing step while the previous word is still untaken
  assign advance  = (state == SEQ_RUN) && !(uw.last && out_valid && !m_tready);
  assign div_start = advance && (uw.op == OP_DIV_START);

  always_comb begin
    unique case (uw.cond)
      C_NEXT:         cond_true = 1'b0;
      C_ALWAYS:       cond_true = 1'b1;
      C_CWND_LT_SSTH: cond_true = cwnd < ssth;
      C_DIV_BUSY:     cond_true = div_busy;
      C_FR_HIT:       cond_true = (in_dup == DUP_W'(retx_thr)) && !rec;
      C_NOT_REC:      cond_true = !rec;
      default:        cond_true = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      SEQ_IDLE: begin
        if (accept) begin
          state_next = SEQ_RUN;
          unique case (func_t'(s_tuser))
            FUNC_START:   pc_next = ENT_START;
            FUNC_NEW_ACK: pc_next = ENT_NEW_ACK;
            FUNC_DUP_ACK: pc_next = ENT_DUP_ACK;
            FUNC_TIMEOUT: pc_next = ENT_TIMEOUT;
          endcase
        end
      end
      SEQ_RUN: begin
        if (advance) begin
          priority if (uw.last) begin
            state_next = SEQ_IDLE;
          end else if (cond_true) begin
            pc_next = uw.target;
          end else begin
            pc_next = pc + PC_W'(1);
          end
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  // Shared 16x16 multiplier feeding the scratch register
  assign mul_a   = (uw.op == OP_TMP_INIT_MUL) ? SEG_W'(init_seg) : seg;
  assign product = WIN_W'(mul_a) * WIN_W'(seg);

  assign two_seg     = WIN_W'({seg, 1'b0});
  assign three_seg   = two_seg + WIN_W'(seg);
  assign half_flight = in_flight >> 1;
  assign halved      = (half_flight > two_seg) ? half_flight : two_seg;
  assign quo_step    = (quo == '0) ? WIN_W'(1) : quo;

  always_comb begin
    cwnd_next = cwnd;
    ssth_next = ssth;
    rec_next  = rec;
    retx_next = retx;
    pend_next = pend;
    tmp_next  = tmp;
    if (advance) begin
      unique case (uw.op)
        OP_NOP:          ;
        OP_TMP_INIT_MUL: tmp_next = product;
        OP_TMP_SQ:       tmp_next = product;
        OP_LOAD_START: begin
          cwnd_next = tmp;
          ssth_next = init_ssth;
        end
        OP_EXIT_REC: begin
          if (rec) begin
            cwnd_next = ssth;
            rec_next  = 1'b0;
          end
        end
        OP_DIV_START:    ;
        OP_CWND_ADD_Q:   cwnd_next = sat_add(cwnd, quo_step);
        OP_CWND_ADD_SEG: cwnd_next = sat_add(cwnd, WIN_W'(seg));
        OP_FR_SSTH: begin
          ssth_next = halved;
          rec_next  = 1'b1;
          retx_next = 1'b1;
        end
        OP_FR_CWND:      cwnd_next = sat_add(ssth, three_seg);
        OP_INFLATE: begin
          cwnd_next = sat_add(cwnd, WIN_W'(seg));
          pend_next = 1'b1;
        end
        OP_TIMEOUT: begin
          rec_next = 1'b0;
          if (in_active) begin
            ssth_next = halved;
            cwnd_next = WIN_W'(seg);
            retx_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cwnd <= '0;
      ssth <= SSTH_RESET;
      rec  <= 1'b0;
    end else begin
      cwnd <= cwnd_next;
      ssth <= ssth_next;
      rec  <= rec_next;
    end
  end

  // Per-event flags start clear on every accepted word
  always_ff @(posedge clk) begin
    tmp <= tmp_next;
    if (accept) begin
      retx      <= 1'b0;
      pend      <= 1'b0;
      in_dup    <= s_tdata[15:0];
      in_flight <= s_tdata[47:16];
      in_rwnd   <= s_tdata[79:48];
      in_active <= s_tdata[80];
    end else begin
      retx <= retx_next;
      pend <= pend_next;
    end
  end

  tcpcw_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tmp),
    .divisor  (cwnd),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Output register, loaded from the closing step's new state
  assign send_win = (in_rwnd < cwnd_next) ? in_rwnd : cwnd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && uw.last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && uw.last) begin
      out_data <= {(OUT_W - 99)'(0), pend_next, retx_next, send_win, rec_next,
                   ssth_next, cwnd_next};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ----- tb/sv/tcp_reno_congestion_window_tb.sv -----
// Self-checking testbench for the Reno congestion window engine: directed
// rows, then randomised event phases, all scored against a local predictor.
// Depends on tcpcw_pkg and the tcp_reno_congestion_window RTL.
module tcp_reno_congestion_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpcw_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_SETTLE  = 6;    // lets the block return to idle
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_EVENTS = 250;
  localparam int HOLD_STRETCH = 400;

  // One accepted event word and one window state word, in port field order.
  typedef struct packed {
    func_t       func;
    logic [15:0] dup;
    logic [31:0] flight;
    logic [31:0] rwnd;
    logic        active;
  } ack_event_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic        recovery;
    logic [31:0] send_window;
    logic        retx;
    logic        pending;
  } window_word_t;

  // A directed row is either a register load or an event, optionally with
  // a hand-typed expectation that replaces the predicted one.
  typedef struct packed {
    logic         load;
    logic [15:0]  seg;
    logic [7:0]   retx;
    logic [7:0]   init;
    logic [31:0]  ssth;
    ack_event_t   ev;
    logic         typed;
    window_word_t want;
  } script_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic [FUNC_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CADDR_W-1:0]   cfg_addr = '0;
  logic [WIN_W-1:0]     cfg_wdata = '0;

  // Predictor copy of the registers and the connection state, at reset.
  logic [15:0] cfg_seg       = 16'd536;
  logic [7:0]  cfg_retx      = 8'd3;
  logic [7:0]  cfg_init_seg  = 8'd1;
  logic [31:0] cfg_init_ssth = 32'd65535;
  logic [31:0] win_cwnd      = '0;
  logic [31:0] win_ssthresh  = 32'd65535;
  logic        win_recovery  = 1'b0;

  window_word_t expected_windows[$];
  script_row_t  directed_rows[$];
  int           mismatches   = 0;
  int           words_seen   = 0;
  int           hold_cycles  = 0;
  int           cycle_count  = 0;
  logic         no_gaps      = 1'b0;

  tcp_reno_congestion_window dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Add with clamping at the top of the 32-bit window.
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = 65'(a) + 65'(b);
    return (sum > 65'(WIN_MAX)) ? WIN_MAX : sum[31:0];
  endfunction

  // New threshold after a loss: half the flight, never under two segments.
  function automatic logic [31:0] halve_flight(logic [31:0] flight);
    logic [31:0] floor2;
    floor2 = 32'(cfg_seg) << 1;
    return ((flight >> 1) > floor2) ? (flight >> 1) : floor2;
  endfunction

  // Advance the predicted connection state by one event and return the word
  // the block should emit for it.
  function automatic window_word_t reno_update(ack_event_t ev);
    window_word_t w;
    logic [63:0]  step;
    w = '0;
    case (ev.func)
      FUNC_START: begin
        // recovery flag is deliberately left alone on start
        win_cwnd     = 32'(cfg_init_seg) * 32'(cfg_seg);
        win_ssthresh = cfg_init_ssth;
      end
      FUNC_NEW_ACK: begin
        if (win_recovery) begin
          win_cwnd     = win_ssthresh;
          win_recovery = 1'b0;
        end
        if (win_cwnd < win_ssthresh) begin
          win_cwnd = sat_add(win_cwnd, 64'(cfg_seg));
        end else begin
          // a zero divisor yields an all-ones quotient, as the divider does
          step = (win_cwnd == '0) ? 64'(WIN_MAX)
                                  : (64'(cfg_seg) * 64'(cfg_seg)) / 64'(win_cwnd);
          if (step < 64'd1) step = 64'd1;
          win_cwnd = sat_add(win_cwnd, step);
        end
      end
      FUNC_DUP_ACK: begin
        // full-width compare: 0x0103 must not match a threshold of 3
        if (32'(ev.dup) == 32'(cfg_retx) && !win_recovery) begin
          win_ssthresh = halve_flight(ev.flight);
          win_cwnd     = sat_add(win_ssthresh, 64'(cfg_seg) * 64'd3);
          win_recovery = 1'b1;
          w.retx       = 1'b1;
        end else if (win_recovery) begin
          win_cwnd  = sat_add(win_cwnd, 64'(cfg_seg));
          w.pending = 1'b1;
        end
      end
      FUNC_TIMEOUT: begin
        win_recovery = 1'b0;
        if (ev.active) begin
          win_ssthresh = halve_flight(ev.flight);
          win_cwnd     = 32'(cfg_seg);
          w.retx       = 1'b1;
        end
      end
      default: ;
    endcase
    w.cwnd        = win_cwnd;
    w.ssthresh    = win_ssthresh;
    w.recovery    = win_recovery;
    w.send_window = (ev.rwnd < win_cwnd) ? ev.rwnd : win_cwnd;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] word %0d: %s got %h want %h", $realtime, words_seen, what, got, want);
    mismatches++;
  endtask

  // Score one delivered word against the oldest expectation.
  task automatic check_window(window_word_t got);
    window_word_t want;
    if (expected_windows.size() == 0) begin
      report_mismatch("word with nothing expected, cwnd", got.cwnd, '0);
      return;
    end
    want = expected_windows.pop_front();
    if (got.cwnd !== want.cwnd) report_mismatch("cwnd", got.cwnd, want.cwnd);
    if (got.ssthresh !== want.ssthresh)
      report_mismatch("ssthresh", got.ssthresh, want.ssthresh);
    if (got.recovery !== want.recovery)
      report_mismatch("in_fast_recovery", 32'(got.recovery), 32'(want.recovery));
    if (got.send_window !== want.send_window)
      report_mismatch("send_window", got.send_window, want.send_window);
    if (got.retx !== want.retx)
      report_mismatch("retransmit_now", 32'(got.retx), 32'(want.retx));
    if (got.pending !== want.pending)
      report_mismatch("send_pending", 32'(got.pending), 32'(want.pending));
  endtask

  // Offer one event word, hold it until accepted, then log its prediction.
  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_word(ack_event_t ev, logic typed, window_word_t want);
    window_word_t predicted;
    while (!no_gaps && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.func;
    s_tdata  <= {7'b0, ev.active, ev.rwnd, ev.flight, ev.dup};
    do @(posedge clk); while (!s_tready);
    predicted = reno_update(ev);
    expected_windows.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold until every word is back and the block is idle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; only legal when idle.
  task automatic load_config(logic [15:0] seg, logic [7:0] retx, logic [7:0] init,
                             logic [31:0] ssth);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SEGMENT_SIZE;
    cfg_wdata <= 32'(seg);
    @(posedge clk);
    cfg_addr  <= REG_RETX_THRESH;
    cfg_wdata <= 32'(retx);
    @(posedge clk);
    cfg_addr  <= REG_INIT_CWND_SEG;
    cfg_wdata <= 32'(init);
    @(posedge clk);
    cfg_addr  <= REG_INIT_SSTHRESH;
    cfg_wdata <= ssth;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_seg       = seg;
    cfg_retx      = retx;
    cfg_init_seg  = init;
    cfg_init_ssth = ssth;
  endtask

  function automatic void add_config(logic [15:0] seg, logic [7:0] retx, logic [7:0] init,
                                     logic [31:0] ssth);
    script_row_t r;
    r      = '0;
    r.load = 1'b1;
    r.seg  = seg;
    r.retx = retx;
    r.init = init;
    r.ssth = ssth;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_event(func_t f, logic [15:0] dup, logic [31:0] flight,
                                    logic [31:0] rwnd, logic active,
                                    logic typed = 1'b0, window_word_t want = '0);
    script_row_t r;
    r           = '0;
    r.ev.func   = f;
    r.ev.dup    = dup;
    r.ev.flight = flight;
    r.ev.rwnd   = rwnd;
    r.ev.active = active;
    r.typed     = typed;
    r.want      = want;
    directed_rows.push_back(r);
  endfunction

  // Receiver: score words, then pick tready for the next edge. A requested
  // hold-off is counted down here while the sender keeps pushing.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        words_seen++;
        check_window('{m_tdata[31:0], m_tdata[63:32], m_tdata[64],
                       m_tdata[96:65], m_tdata[97], m_tdata[98]});
      end
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= no_gaps || ($urandom_range(99) >= 15);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words outstanding",
             cycle_count, expected_windows.size());
    $display("** tcp_reno_congestion_window: FAILED **");
    $finish;
  end

  initial begin
    script_row_t row;
    ack_event_t  ev;
    int          dup_run;
    int          pick;

    // Reset registers: seg 536, threshold 3, one initial segment, ssthresh 65535.
    // Before any start the window is zero: an idle timeout only echoes state.
    add_event(FUNC_TIMEOUT, 16'h0000, 32'h0, 32'h0, 1'b0,
              1'b1, '{32'd0, 32'd65535, 1'b0, 32'd0, 1'b0, 1'b0});
    // First new ACK from a zero window is slow start: one segment.
    add_event(FUNC_NEW_ACK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              1'b1, '{32'd536, 32'd65535, 1'b0, 32'd536, 1'b0, 1'b0});
    // Start reloads one segment; a small receiver window caps send_window.
    add_event(FUNC_START, 16'h1234, 32'h5555_AAAA, 32'd100, 1'b1,
              1'b1, '{32'd536, 32'd65535, 1'b0, 32'd100, 1'b0, 1'b0});
    add_event(FUNC_NEW_ACK, 16'h0, 32'd4000, 32'hFFFF_FFFF, 1'b0);
    add_event(FUNC_DUP_ACK, 16'd2, 32'd10000, 32'hFFFF_FFFF, 1'b0);  // below threshold
    add_event(FUNC_DUP_ACK, 16'd3, 32'd10000, 32'd3000, 1'b0);       // fast retransmit
    add_event(FUNC_DUP_ACK, 16'd4, 32'd10000, 32'hFFFF_FFFF, 1'b0);  // inflate
    add_event(FUNC_DUP_ACK, 16'h0103, 32'd10000, 32'hFFFF_FFFF, 1'b1);
    add_event(FUNC_NEW_ACK, 16'h0, 32'd8000, 32'hFFFF_FFFF, 1'b0);   // leave recovery
    add_event(FUNC_DUP_ACK, 16'h0103, 32'd8000, 32'hFFFF_FFFF, 1'b0); // wide count, no hit
    add_event(FUNC_DUP_ACK, 16'd3, 32'h0, 32'hFFFF_FFFF, 1'b0);      // two-segment floor
    add_event(FUNC_TIMEOUT, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // idle timeout
    add_event(FUNC_TIMEOUT, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_event(FUNC_TIMEOUT, 16'h0, 32'h0, 32'h0, 1'b1);
    // Upper register extremes, with a zero initial threshold.
    add_config(16'hFFFF, 8'hFF, 8'hFF, 32'h0);
    add_event(FUNC_START, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_event(FUNC_NEW_ACK, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_event(FUNC_DUP_ACK, 16'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_event(FUNC_DUP_ACK, 16'd255, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    // Zero start window with zero threshold: divisor is zero, window pins high.
    add_config(16'd1, 8'd0, 8'd0, 32'h0);
    add_event(FUNC_TIMEOUT, 16'h0, 32'h0, 32'h0, 1'b0);
    add_event(FUNC_START, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0,
              1'b1, '{32'd0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0});
    add_event(FUNC_NEW_ACK, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0,
              1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0});
    add_event(FUNC_NEW_ACK, 16'h0, 32'h0, 32'd12345, 1'b0);          // stays saturated
    add_event(FUNC_DUP_ACK, 16'd0, 32'd5, 32'hFFFF_FFFF, 1'b0);      // zero threshold hits
    // Zero segment size; recovery is still set going into start.
    add_config(16'd0, 8'd1, 8'd255, 32'hFFFF_FFFF);
    add_event(FUNC_START, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_event(FUNC_NEW_ACK, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    add_event(FUNC_DUP_ACK, 16'd1, 32'd77, 32'hFFFF_FFFF, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed rows; register loads wait for the block to drain.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.load) begin
        wait_drained();
        load_config(row.seg, row.retx, row.init, row.ssth);
      end else begin
        send_word(row.ev, row.typed, row.want);
      end
    end

    // Random phases: mostly start / ACK / duplicate-run / timeout traffic with
    // running duplicate counts, plus some stray counts and wild flights.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      no_gaps = (phase == 0);
      case (phase)
        1:       load_config(16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        2:       load_config(16'd1, 8'd1, 8'd1, 32'd0);
        default: load_config(($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(1, 1460)),
                             ($urandom_range(1) == 0) ? 8'($urandom_range(1, 6))
                                                      : 8'($urandom),
                             8'($urandom_range(0, 12)),
                             ($urandom_range(1) == 0) ? 32'($urandom)
                                                      : 32'($urandom_range(0, 200000)));
      endcase
      dup_run = 0;
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        // long receiver hold-off while words keep coming
        if (phase == 3 && n == 20) hold_cycles = HOLD_STRETCH;
        // sender pause until everything is back
        if (phase == 5 && n == PHASE_EVENTS / 2) wait_drained();
        pick      = $urandom_range(99);
        ev.dup    = 16'($urandom);
        ev.flight = ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 20));
        ev.rwnd   = ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 20));
        ev.active = 1'($urandom_range(1));
        if (n == 0 || pick < 4) begin
          ev.func = FUNC_START;
          dup_run = 0;
        end else if (pick < 45) begin
          ev.func = FUNC_NEW_ACK;
          dup_run = 0;
        end else if (pick < 85) begin
          ev.func = FUNC_DUP_ACK;
          dup_run++;
          pick = $urandom_range(9);
          if (pick < 6)      ev.dup = 16'(dup_run);
          else if (pick < 8) ev.dup = 16'(cfg_retx);
        end else begin
          ev.func   = FUNC_TIMEOUT;
          ev.active = ($urandom_range(9) != 0);
          dup_run   = 0;
        end
        send_word(ev, 1'b0, '0);
      end
    end

    wait_drained();
    if (expected_windows.size() != 0)
      report_mismatch("words never delivered", 32'(expected_windows.size()), '0);
    if (mismatches == 0)
      $display("** tcp_reno_congestion_window: PASSED **");
    else
      $display("** tcp_reno_congestion_window: FAILED **");
    $finish;
  end

endmodule

// ----- tcp_reno_congestion_window.f -----
rtl/tcpcw_pkg.sv
rtl/tcpcw_divider.sv
rtl/tcp_reno_congestion_window.sv
tb/sv/tcp_reno_congestion_window_tb.sv
